// ===== hw/rtl/bdq_pkg.sv =====
`default_nettype none

package bdq_pkg;

    // store size and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    // request codes
    typedef enum logic [2:0] {
        ACT_INSERT_FRONT = 3'd0,
        ACT_INSERT_BACK  = 3'd1,
        ACT_REMOVE_FRONT = 3'd2,
        ACT_REMOVE_BACK  = 3'd3,
        ACT_SEARCH       = 3'd4
    } action_t;

    // status codes
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // per-cell update select
    typedef struct packed {
        logic take_prev;
        logic take_next;
        logic load;
    } cell_ctrl_t;

    // search token walking down the chain
    typedef struct packed {
        logic                     live;
        logic [CNT_W-1:0]         remain;
        logic signed [DATA_W-1:0] key;
        logic                     found;
    } token_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bounded_deque_with_search.sv =====
// insert and remove: result registered in the cycle after the transaction is accepted,
//   a new transaction can be taken every cycle while the result side keeps up
// search: the key walks the chain of CAPACITY cells one cell a cycle, and the result is
//   registered once the key leaves the last cell; input is held off while the search
//   runs, so the next transaction is taken only after the search result is registered
// reset (aresetn low, synchronous) empties the store and drops any search or result
`default_nettype none

module bounded_deque_with_search (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [2:0]                        s_action,
    input  wire logic signed [bdq_pkg::DATA_W-1:0] s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_status,
    output logic                                   m_found,
    output logic [bdq_pkg::COUNT_W-1:0]            m_count
);

    localparam int N     = bdq_pkg::CAPACITY;
    localparam int CNT_W = bdq_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    state_t                              state_reg, state_next;
    logic [CNT_W-1:0]                    occ_reg, occ_next;
    logic                                m_valid_reg, m_valid_next;
    bdq_pkg::status_t                    status_reg, status_next;
    logic                                found_reg, found_next;
    logic [CNT_W-1:0]                    count_reg, count_next;

    logic                                accept;
    logic                                full;
    logic                                empty;
    bdq_pkg::action_t                    act;
    bdq_pkg::status_t                    req_status;
    logic                                shift_down;
    logic                                shift_up;
    logic                                load_back;
    logic                                go_search;
    logic [CNT_W+bdq_pkg::COUNT_W-1:0]   count_ext;

    logic signed [bdq_pkg::DATA_W-1:0]   entries [N];
    bdq_pkg::token_t                     toks [N];
    bdq_pkg::cell_ctrl_t                 ctrls [N];
    bdq_pkg::token_t                     tok_head;

    // handshake
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign full    = (occ_reg == CNT_W'(N));
    assign empty   = (occ_reg == '0);
    assign act     = bdq_pkg::action_t'(s_action);

    // decode the request
    always_comb begin
        req_status = bdq_pkg::STAT_DONE;
        occ_next   = occ_reg;
        shift_down = 1'b0;
        shift_up   = 1'b0;
        load_back  = 1'b0;
        go_search  = 1'b0;
        unique case (act)
            bdq_pkg::ACT_INSERT_FRONT: begin
                if (full) begin
                    req_status = bdq_pkg::STAT_FULL;
                end else begin
                    shift_down = accept;
                    occ_next   = occ_reg + 1'b1;
                end
            end
            bdq_pkg::ACT_INSERT_BACK: begin
                if (full) begin
                    req_status = bdq_pkg::STAT_FULL;
                end else begin
                    load_back = accept;
                    occ_next  = occ_reg + 1'b1;
                end
            end
            bdq_pkg::ACT_REMOVE_FRONT: begin
                if (empty) begin
                    req_status = bdq_pkg::STAT_EMPTY;
                end else begin
                    shift_up = accept;
                    occ_next = occ_reg - 1'b1;
                end
            end
            bdq_pkg::ACT_REMOVE_BACK: begin
                if (empty) begin
                    req_status = bdq_pkg::STAT_EMPTY;
                end else begin
                    occ_next = occ_reg - 1'b1;
                end
            end
            bdq_pkg::ACT_SEARCH: begin
                go_search = 1'b1;
            end
            default: begin
                req_status = bdq_pkg::STAT_DONE;
            end
        endcase
    end

    // token entering the first cell
    always_comb begin
        tok_head.live   = accept && go_search;
        tok_head.remain = occ_reg;
        tok_head.key    = s_value;
        tok_head.found  = 1'b0;
    end

    // chain of cells, cell 0 holds the front
    for (genvar i = 0; i < N; i++) begin : g_cell
        logic signed [bdq_pkg::DATA_W-1:0] prev_val;
        logic signed [bdq_pkg::DATA_W-1:0] next_val;
        bdq_pkg::token_t                   tok_in;

        if (i == 0) begin : g_first
            assign prev_val = s_value;
            assign tok_in   = tok_head;
        end else begin : g_mid
            assign prev_val = entries[i-1];
            assign tok_in   = toks[i-1];
        end

        if (i == N - 1) begin : g_last
            assign next_val = entries[i];
        end else begin : g_notlast
            assign next_val = entries[i+1];
        end

        always_comb begin
            ctrls[i].take_prev = shift_down;
            ctrls[i].take_next = shift_up;
            ctrls[i].load      = load_back && (occ_reg == CNT_W'(i));
        end

        bdq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrls[i]),
            .prev_val  (prev_val),
            .next_val  (next_val),
            .load_val  (s_value),
            .tok_in    (tok_in),
            .entry_out (entries[i]),
            .tok_out   (toks[i])
        );
    end

    // sequencing and result register
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        count_next   = count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (go_search) begin
                        state_next = ST_SEARCH;
                    end else begin
                        m_valid_next = 1'b1;
                        status_next  = req_status;
                        found_next   = 1'b0;
                        count_next   = occ_next;
                    end
                end
            end
            ST_SEARCH: begin
                if (toks[N-1].live) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    status_next  = bdq_pkg::STAT_DONE;
                    found_next   = toks[N-1].found;
                    count_next   = occ_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                occ_reg <= occ_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        found_reg  <= found_next;
        count_reg  <= count_next;
    end

    // outputs, count masked to its field
    assign count_ext = {{bdq_pkg::COUNT_W{1'b0}}, count_reg};
    assign m_valid   = m_valid_reg;
    assign m_status  = status_reg;
    assign m_found   = found_reg;
    assign m_count   = count_ext[bdq_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/bdq_cell.sv =====
`default_nettype none

module bdq_cell (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire bdq_pkg::cell_ctrl_t              ctrl,
    input  wire logic signed [bdq_pkg::DATA_W-1:0] prev_val,
    input  wire logic signed [bdq_pkg::DATA_W-1:0] next_val,
    input  wire logic signed [bdq_pkg::DATA_W-1:0] load_val,
    input  wire bdq_pkg::token_t                  tok_in,
    output logic signed [bdq_pkg::DATA_W-1:0]     entry_out,
    output bdq_pkg::token_t                       tok_out
);

    logic signed [bdq_pkg::DATA_W-1:0] entry_reg;
    logic signed [bdq_pkg::DATA_W-1:0] entry_next;
    bdq_pkg::token_t                   tok_reg;
    bdq_pkg::token_t                   tok_next;
    logic                              hit;

    // entry update from neighbors or from the request
    always_comb begin
        priority if (ctrl.take_prev) begin
            entry_next = prev_val;
        end else if (ctrl.take_next) begin
            entry_next = next_val;
        end else if (ctrl.load) begin
            entry_next = load_val;
        end else begin
            entry_next = entry_reg;
        end
    end

    // compare against the passing key while entries remain
    assign hit = (tok_in.remain != '0) && (entry_reg == tok_in.key);

    always_comb begin
        tok_next        = tok_in;
        tok_next.found  = tok_in.found | hit;
        tok_next.remain = (tok_in.remain == '0) ? '0 : tok_in.remain - 1'b1;
    end

    // entry and token, only the token valid is reset
    always_ff @(posedge aclk) begin
        entry_reg      <= entry_next;
        tok_reg.remain <= tok_next.remain;
        tok_reg.key    <= tok_next.key;
        tok_reg.found  <= tok_next.found;
        if (!aresetn) begin
            tok_reg.live <= 1'b0;
        end else begin
            tok_reg.live <= tok_next.live;
        end
    end

    assign entry_out = entry_reg;
    assign tok_out   = tok_reg;

endmodule

`default_nettype wire
